@@ rtl/core/shp_pkg.sv @@
package shp_pkg;

    // frame geometry limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // field and counter widths
    localparam int CHAN_W    = 8;
    localparam int NUM_CH    = 3;
    localparam int PIX_W     = CHAN_W * NUM_CH;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
    localparam int FILL_W    = $clog2(MAX_WIDTH + 1);
    localparam int ACC_W     = CHAN_W + 4;

    // output queue sizing
    localparam int QUEUE_DEPTH = 3;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // register values after reset
    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;
    localparam logic RST_COLOR_MODE = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_COLOR_MODE   = 2'd2
    } t_cfg_idx;

    // the five weighted neighbors of one channel
    typedef struct packed {
        logic [CHAN_W-1:0] ctr;
        logic [CHAN_W-1:0] top;
        logic [CHAN_W-1:0] bot;
        logic [CHAN_W-1:0] lft;
        logic [CHAN_W-1:0] rgt;
    } t_taps;

    // one result pixel as it waits in the output queue
    typedef struct packed {
        logic                           frame_end;
        logic [NUM_CH-1:0][CHAN_W-1:0]  chan;
    } t_result;

    // last column index of a line, zero width taken as one, saturated to the line buffer
    function automatic logic [COL_W-1:0] f_width_last(input logic [CFG_W-1:0] v);
        logic [COL_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (32'(v) > MAX_WIDTH) begin
            res = COL_W'(MAX_WIDTH - 1);
        end else begin
            res = COL_W'(v - 1'b1);
        end
        return res;
    endfunction

    // line count, zero taken as one, saturated to the frame limit
    function automatic logic [ROW_W-1:0] f_height(input logic [CFG_W-1:0] v);
        logic [ROW_W-1:0] res;
        if (v == '0) begin
            res = ROW_W'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            res = ROW_W'(MAX_HEIGHT);
        end else begin
            res = ROW_W'(v);
        end
        return res;
    endfunction

endpackage

@@ rtl/core/sharpen_3x3_zero_pad_top.sv @@
// results: pixel (r,c) is filtered from the second-stage registers and queued for the
//   master side once pixel (r+1,c) is accepted; the first line gives no result
// throughput: one pixel per cycle while the output queue has room, set by the single write port of each line memory
// reset: i_rst_n synchronous, active low; clears counters, fill mark and output queue,
//   loads the register reset values; line memories are not swept, entries past the
//   fill mark read as zero, so no clearing pass follows reset
module sharpen_3x3_zero_pad_top import shp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // chan0_in, chan1_in, chan2_in
    input  logic                 s_axis_tuser,   // mode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // chan0_out, chan1_out, chan2_out
    output logic                 m_axis_tlast,   // frame_end
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // configuration
    logic [COL_W-1:0]  r_w_last;
    logic [ROW_W-1:0]  r_h_eff;
    logic              r_color;

    // position counters and memory fill mark
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [FILL_W-1:0] r_fill;

    // line memories
    logic [PIX_W-1:0]  r_mid_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  r_up_mem  [MAX_WIDTH];
    logic [PIX_W-1:0]  r_mid_rd0;
    logic [PIX_W-1:0]  r_mid_rd1;
    logic [PIX_W-1:0]  r_up_rd;

    // second stage
    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_col;
    logic [PIX_W-1:0]  r_s1_px;
    logic              r_s1_has;
    logic              r_s1_top_en;
    logic              r_s1_lft_en;
    logic              r_s1_rgt_en;
    logic              r_s1_end;
    logic              r_f_ctr;
    logic              r_f_rgt;
    logic              r_ok_ctr;
    logic              r_ok_rgt;
    logic [PIX_W-1:0]  r_fwd_px;
    logic [PIX_W-1:0]  r_fwd_ctr;
    logic [PIX_W-1:0]  r_left;

    logic              accept;
    logic [COL_W-1:0]  col;
    logic [COL_W:0]    col_nx;
    logic [ROW_W-1:0]  row;
    logic              flush;
    logic              last_col;
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  s1_ctr;
    logic [PIX_W-1:0]  s1_top;
    logic [PIX_W-1:0]  s1_lft;
    logic [PIX_W-1:0]  s1_rgt;
    logic              push;
    logic [QLVL_W-1:0] q_level;
    logic [NUM_CH-1:0][CHAN_W-1:0] lane_pix;

    // configuration writes, always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= f_width_last(CFG_W'(RST_FRAME_WIDTH));
            r_h_eff  <= f_height(CFG_W'(RST_FRAME_HEIGHT));
            r_color  <= RST_COLOR_MODE;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_w_last <= f_width_last(i_cfg_data);
                CFG_FRAME_HEIGHT: r_h_eff  <= f_height(i_cfg_data);
                CFG_COLOR_MODE:   r_color  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // position of the incoming pixel, clamped to the current geometry
    always_comb begin
        col      = (r_col > r_w_last) ? r_w_last : r_col;
        row      = (r_row > r_h_eff) ? r_h_eff : r_row;
        col_nx   = {1'b0, col} + 1'b1;
        flush    = (row == r_h_eff);
        last_col = (col == r_w_last);
        px       = (flush || s_axis_tuser) ? '0 : s_axis_tdata;
    end

    // room for the pixel in flight plus the queued results
    assign push          = r_s1_valid & r_s1_has;
    assign s_axis_tready = i_rst_n && (({1'b0, q_level} + (QLVL_W + 1)'(push))
                                       < (QLVL_W + 1)'(QUEUE_DEPTH));
    assign accept        = s_axis_tvalid & s_axis_tready;

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= flush ? '0 : ROW_W'(row + 1'b1);
            end else begin
                r_col <= col_nx[COL_W-1:0];
            end
        end
    end

    // columns are always written in rising order from zero, so a fill mark covers reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (r_s1_valid && ({1'b0, r_s1_col} == r_fill)) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // line memories: center and right reads from the middle line, top from the upper line
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mid_mem[r_s1_col] <= r_s1_px;
            r_up_mem[r_s1_col]  <= s1_ctr;
        end
        r_mid_rd0 <= r_mid_mem[col];
        r_mid_rd1 <= r_mid_mem[col_nx[COL_W-1:0]];
        r_up_rd   <= r_up_mem[col];
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    // stage payload, bypass of the write landing in the same cycle as the read
    always_ff @(posedge i_clk) begin
        r_s1_col    <= col;
        r_s1_px     <= px;
        r_s1_has    <= (row != '0);
        r_s1_top_en <= (row > ROW_W'(1));
        r_s1_lft_en <= (col != '0);
        r_s1_rgt_en <= !last_col;
        r_s1_end    <= flush & last_col;
        r_f_ctr     <= r_s1_valid && (r_s1_col == col);
        r_f_rgt     <= r_s1_valid && ({1'b0, r_s1_col} == col_nx);
        r_ok_ctr    <= (FILL_W'(col) < r_fill);
        r_ok_rgt    <= (FILL_W'(col_nx) < r_fill);
        r_fwd_px    <= r_s1_px;
        r_fwd_ctr   <= s1_ctr;
        if (r_s1_valid) begin
            r_left <= s1_ctr;
        end
    end

    // neighbor selection with zero padding
    always_comb begin
        if (r_f_ctr) begin
            s1_ctr = r_fwd_px;
        end else begin
            s1_ctr = r_ok_ctr ? r_mid_rd0 : '0;
        end
        if (!r_s1_rgt_en) begin
            s1_rgt = '0;
        end else if (r_f_rgt) begin
            s1_rgt = r_fwd_px;
        end else begin
            s1_rgt = r_ok_rgt ? r_mid_rd1 : '0;
        end
        if (!r_s1_top_en) begin
            s1_top = '0;
        end else if (r_f_ctr) begin
            s1_top = r_fwd_ctr;
        end else begin
            s1_top = r_ok_ctr ? r_up_rd : '0;
        end
        s1_lft = r_s1_lft_en ? r_left : '0;
    end

    // one lane per color channel
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        t_taps taps;

        always_comb begin
            taps.ctr = s1_ctr[ch*CHAN_W +: CHAN_W];
            taps.top = s1_top[ch*CHAN_W +: CHAN_W];
            taps.bot = r_s1_px[ch*CHAN_W +: CHAN_W];
            taps.lft = s1_lft[ch*CHAN_W +: CHAN_W];
            taps.rgt = s1_rgt[ch*CHAN_W +: CHAN_W];
        end

        shp_lane u_lane (
            .i_taps (taps),
            .o_pix  (lane_pix[ch])
        );
    end

    // merge lanes and queue results for the master side
    shp_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_lanes       (lane_pix),
        .i_frame_end   (r_s1_end),
        .i_color       (r_color),
        .o_level       (q_level),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ rtl/core/shp_lane.sv @@
module shp_lane import shp_pkg::*; (
    input  t_taps             i_taps,
    output logic [CHAN_W-1:0] o_pix
);

    logic [ACC_W-1:0] acc;

    // center weighted by five, minus the top, bottom, left and right neighbors, wraps into a signed accumulator
    always_comb begin
        acc = {2'b00, i_taps.ctr, 2'b00} + ACC_W'(i_taps.ctr)
            - ACC_W'(i_taps.top) - ACC_W'(i_taps.bot)
            - ACC_W'(i_taps.lft) - ACC_W'(i_taps.rgt);
    end

    // clamp to byte range
    always_comb begin
        if (acc[ACC_W-1]) begin
            o_pix = '0;
        end else if (acc[ACC_W-2:CHAN_W] != '0) begin
            o_pix = '1;
        end else begin
            o_pix = acc[CHAN_W-1:0];
        end
    end

endmodule

@@ rtl/core/shp_merge.sv @@
module shp_merge import shp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [NUM_CH-1:0][CHAN_W-1:0] i_lanes,
    input  logic                          i_frame_end,
    input  logic                          i_color,
    output logic [QLVL_W-1:0]             o_level,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [PIX_W-1:0]              m_axis_tdata,   // chan0_out, chan1_out, chan2_out
    output logic                          m_axis_tlast    // frame_end
);

    t_result             res;
    t_result             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_head;
    logic [QPTR_W-1:0]   r_tail;
    logic [QLVL_W-1:0]   r_level;
    logic [QLVL_W-1:0]   n_level;
    logic                pop;

    // combine lanes, upper channels forced to zero in gray mode
    always_comb begin
        res.frame_end = i_frame_end;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            res.chan[ch] = (ch == 0 || i_color) ? i_lanes[ch] : '0;
        end
    end

    assign pop     = m_axis_tvalid & m_axis_tready;
    assign n_level = r_level + QLVL_W'(i_push) - QLVL_W'(pop);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_tail] <= res;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (pop) begin
                r_head <= (r_head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            r_level <= n_level;
        end
    end

    assign o_level       = r_level;
    assign m_axis_tvalid = (r_level != '0);
    assign m_axis_tdata  = r_q[r_head].chan;
    assign m_axis_tlast  = r_q[r_head].frame_end;

endmodule

@@ rtl/core/shp_checker.sv @@
module shp_checker import shp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [PIX_W-1:0] m_axis_tdata,   // chan0_out, chan1_out, chan2_out
    input logic             m_axis_tlast    // frame_end
);

    // no result pending right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a new result follows an accepted pixel, through the stage and queue registers
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching input transaction");

    // input stalls only when results are waiting
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind sharpen_3x3_zero_pad_top shp_checker u_shp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/sv/tb_sharpen_3x3_zero_pad_top.sv @@
module tb_sharpen_3x3_zero_pad_top;
    import shp_pkg::*;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_PIXELS = 1400;
    localparam int MAX_PRINTED   = 50;

    // one pixel on the slave side: pad marks an item that the block reads as zero
    typedef struct packed {
        logic             pad;
        logic [PIX_W-1:0] pix;
    } t_pixel_in;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata = '0;   // chan0_in, chan1_in, chan2_in
    logic                 s_axis_tuser = 1'b0; // mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     m_axis_tdata;        // chan0_out, chan1_out, chan2_out
    logic                 m_axis_tlast;        // frame_end
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // stimulus and expectation stores
    t_pixel_in pixel_queue[$];
    t_result   sharpened_q[$];
    t_pixel_in drive_px;
    logic      idle_en = 1'b1;
    int        src_gap = 0;
    int        snk_gap = 0;
    int        queued_cnt = 0;
    int        taken_cnt = 0;
    int        result_cnt = 0;
    int        frame_cnt = 0;
    int        cfg_cnt = 0;
    int        err_cnt = 0;
    int        stall_cycles = 0;
    logic      px_take;

    // filter state mirrored from the block
    logic [PIX_W-1:0] line_above [MAX_WIDTH];
    logic [PIX_W-1:0] line_mid   [MAX_WIDTH];
    logic [PIX_W-1:0] prev_ctr = '0;
    int               col_cnt = 0;
    int               row_cnt = 0;
    logic [CFG_W-1:0] reg_width = CFG_W'(RST_FRAME_WIDTH);
    logic [CFG_W-1:0] reg_height = CFG_W'(RST_FRAME_HEIGHT);
    logic             reg_color = RST_COLOR_MODE;

    sharpen_3x3_zero_pad_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (err_cnt < MAX_PRINTED) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        err_cnt++;
    endtask

    // zero width or height counts as one, oversize saturates to the line buffer or frame limit
    function automatic int eff_width();
        int w;
        w = int'(reg_width);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(reg_height);
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    // center weighted by five, minus the top, bottom, left and right neighbors, clamped to a byte
    function automatic logic [CHAN_W-1:0] sharpen_tap(input logic [CHAN_W-1:0] c,
                                                      input logic [CHAN_W-1:0] t,
                                                      input logic [CHAN_W-1:0] b,
                                                      input logic [CHAN_W-1:0] l,
                                                      input logic [CHAN_W-1:0] r);
        int acc;
        acc = 5 * int'(c) - int'(t) - int'(b) - int'(l) - int'(r);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        return CHAN_W'(acc);
    endfunction

    // advance the mirrored filter by one accepted pixel
    task automatic filter_pixel(input t_pixel_in it);
        int               w;
        int               h;
        int               col;
        int               row;
        logic             flush_row;
        logic             last_col;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] ctr;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] lft;
        logic [PIX_W-1:0] rgt;
        t_result          res;
        w = eff_width();
        h = eff_height();
        col = (col_cnt >= w) ? w - 1 : col_cnt;
        row = (row_cnt > h) ? h : row_cnt;
        flush_row = (row == h);
        last_col = (col == w - 1);
        px = (flush_row || it.pad) ? '0 : it.pix;
        ctr = line_mid[col];
        if (row >= 1) begin
            top = (row >= 2) ? line_above[col] : '0;
            lft = (col > 0) ? prev_ctr : '0;
            rgt = last_col ? '0 : line_mid[col + 1];
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (ch == 0 || reg_color) begin
                    res.chan[ch] = sharpen_tap(ctr[ch*CHAN_W +: CHAN_W], top[ch*CHAN_W +: CHAN_W],
                                               px[ch*CHAN_W +: CHAN_W], lft[ch*CHAN_W +: CHAN_W],
                                               rgt[ch*CHAN_W +: CHAN_W]);
                end else begin
                    res.chan[ch] = '0;
                end
            end
            res.frame_end = flush_row && last_col;
            sharpened_q.push_back(res);
        end
        prev_ctr = ctr;
        line_above[col] = ctr;
        line_mid[col] = px;
        if (last_col) begin
            col_cnt = 0;
            row_cnt = flush_row ? 0 : row + 1;
        end else begin
            col_cnt = col + 1;
            row_cnt = row;
        end
    endtask

    // pixel source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            px_take = s_axis_tvalid && s_axis_tready;
            if (px_take) begin
                filter_pixel(drive_px);
                taken_cnt++;
            end
            if (!s_axis_tvalid || px_take) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_queue.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (idle_en && $urandom_range(0, 15) == 0) begin
                    src_gap = $urandom_range(0, 15);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    drive_px = pixel_queue.pop_front();
                    s_axis_tdata  <= drive_px.pix;
                    s_axis_tuser  <= drive_px.pad;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // result sink and compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                result_cnt++;
                if (sharpened_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
                                              m_axis_tdata, m_axis_tlast));
                end else begin
                    t_result want;
                    want = sharpened_q.pop_front();
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        if (m_axis_tdata[ch*CHAN_W +: CHAN_W] !== want.chan[ch]) begin
                            report_mismatch($sformatf("result %0d chan%0d got %h want %h",
                                result_cnt, ch, m_axis_tdata[ch*CHAN_W +: CHAN_W],
                                want.chan[ch]));
                        end
                    end
                    if (m_axis_tlast !== want.frame_end) begin
                        report_mismatch($sformatf("result %0d frame_end got %b want %b",
                                                  result_cnt, m_axis_tlast, want.frame_end));
                    end
                    if (want.frame_end) frame_cnt++;
                end
            end
            if (snk_gap != 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 15) == 0) begin
                snk_gap = $urandom_range(0, 15);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one register write transaction, mirrored when accepted
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FRAME_WIDTH:  reg_width = val;
            CFG_FRAME_HEIGHT: reg_height = val;
            CFG_COLOR_MODE:   reg_color = val[0];
            default: ;
        endcase
        cfg_cnt++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off until every pixel is taken and every result is back
    task automatic drain_block();
        @(posedge i_clk);
        while (taken_cnt != queued_cnt || sharpened_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_px(input logic pad, input logic [CHAN_W-1:0] c0,
                            input logic [CHAN_W-1:0] c1, input logic [CHAN_W-1:0] c2);
        pixel_queue.push_back('{pad: pad, pix: {c2, c1, c0}});
        queued_cnt++;
    endtask

    // byte biased toward the clamp extremes
    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_random(input int n, input int pad_pct);
        for (int i = 0; i < n; i++) begin
            queue_px($urandom_range(0, 99) < pad_pct, rand_chan(), rand_chan(), rand_chan());
        end
    endtask

    function automatic int pixels_to_frame_end();
        int w;
        int h;
        int col;
        int row;
        w = eff_width();
        h = eff_height();
        col = (col_cnt >= w) ? w - 1 : col_cnt;
        row = (row_cnt > h) ? h : row_cnt;
        return (h - row) * w + (w - col);
    endfunction

    function automatic logic [CFG_W-1:0] pick_size(input int hi);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_W'(2048);
            2:       return '1;
            3:       return CFG_W'($urandom_range(1, 64));
            default: return CFG_W'($urandom_range(1, hi));
        endcase
    endfunction

    // stimulus
    initial begin
        int rand_px;
        int n;
        int remaining;
        rand_px = 0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            line_above[i] = '0;
            line_mid[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small color frame: clamp extremes and a padded item inside the frame
        write_reg(CFG_FRAME_WIDTH, 12'd3);
        write_reg(CFG_FRAME_HEIGHT, 12'd2);
        write_reg(CFG_COLOR_MODE, 12'd1);
        queue_px(1'b0, 8'hFF, 8'hFF, 8'hFF);
        queue_px(1'b0, 8'h00, 8'h00, 8'h00);
        queue_px(1'b0, 8'hFF, 8'h00, 8'h80);
        queue_px(1'b0, 8'h00, 8'hFF, 8'h00);
        queue_px(1'b1, 8'hFF, 8'hFF, 8'hFF);
        queue_px(1'b0, 8'h12, 8'h34, 8'h56);
        // flush line: data ignored whatever the mode bit
        queue_px(1'b1, 8'h5A, 8'hA5, 8'h3C);
        queue_px(1'b0, 8'hFF, 8'hFF, 8'hFF);
        queue_px(1'b1, 8'hAA, 8'h55, 8'hAA);
        drain_block();

        // gray frame, single line, upper channels carry junk
        write_reg(CFG_FRAME_WIDTH, 12'd4);
        write_reg(CFG_FRAME_HEIGHT, 12'd1);
        write_reg(CFG_COLOR_MODE, 12'd0);
        write_reg(CFG_UNUSED, 12'hFFF);
        queue_px(1'b0, 8'hFF, 8'hFF, 8'hFF);
        queue_px(1'b0, 8'h00, 8'h80, 8'hFF);
        queue_px(1'b0, 8'hFF, 8'h00, 8'h00);
        queue_px(1'b1, 8'hFF, 8'hFF, 8'hFF);
        queue_px(1'b0, 8'h01, 8'h02, 8'h03);
        queue_px(1'b0, 8'hFF, 8'hFF, 8'hFF);
        queue_px(1'b1, 8'h00, 8'h00, 8'h00);
        queue_px(1'b0, 8'h80, 8'h7F, 8'hFE);
        drain_block();

        // oversized width: one short line, widen past the buffer, then shrink mid line
        write_reg(CFG_FRAME_WIDTH, 12'd2);
        write_reg(CFG_COLOR_MODE, 12'd1);
        queue_random(2, 10);
        drain_block();
        write_reg(CFG_FRAME_WIDTH, 12'hFFF);
        queue_random(200, 10);
        drain_block();
        write_reg(CFG_FRAME_WIDTH, 12'd3);
        queue_random(pixels_to_frame_end(), 10);
        drain_block();

        // oversized height, one pixel per line, then shrink below the current row
        write_reg(CFG_FRAME_WIDTH, 12'd1);
        write_reg(CFG_FRAME_HEIGHT, 12'hFFF);
        queue_random(100, 10);
        drain_block();
        write_reg(CFG_FRAME_HEIGHT, 12'd50);
        queue_random(pixels_to_frame_end(), 10);
        drain_block();

        // random frames, with partial frames and resizes in between
        while (rand_px < RANDOM_PIXELS) begin
            idle_en <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0) write_reg(CFG_FRAME_WIDTH, pick_size(12));
            if ($urandom_range(0, 1) == 0) write_reg(CFG_FRAME_HEIGHT, pick_size(6));
            if ($urandom_range(0, 2) == 0) write_reg(CFG_COLOR_MODE, CFG_W'($urandom));
            if ($urandom_range(0, 19) == 0) write_reg(CFG_UNUSED, CFG_W'($urandom));
            remaining = pixels_to_frame_end();
            if ($urandom_range(0, 7) == 0 || remaining > 400) begin
                n = $urandom_range(1, 40);
            end else begin
                n = remaining;
            end
            queue_random(n, 8);
            rand_px += n;
            drain_block();
        end

        // closing frames with both sides always ready
        idle_en <= 1'b0;
        write_reg(CFG_FRAME_WIDTH, 12'd8);
        write_reg(CFG_FRAME_HEIGHT, 12'd4);
        write_reg(CFG_COLOR_MODE, 12'd1);
        queue_random(pixels_to_frame_end(), 5);
        queue_random(40, 5);
        drain_block();

        $display("pixels sent %0d, results checked %0d, frames ended %0d, register writes %0d",
                 taken_cnt, result_cnt, frame_cnt, cfg_cnt);
        $display("covered clamp extremes, gray and color, flush items, oversized and shrunk frames");
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
